// File: design/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: design/cmap_pkg.sv
// Types shared by the cluster map cache cells and top level.
`timescale 1ns / 1ps
package cmap_pkg;

  typedef enum logic [1:0] {
    MODE_LOOKUP  = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_INV_FILE = 2'd2,
    MODE_INV_DEV = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] device_id;
    logic [31:0] file_id;
    logic [15:0] cluster_key;
    logic [15:0] prior_cluster;
    logic [15:0] disk_cl;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        exact;
    logic [15:0] out_file_cl;
    logic [15:0] out_disk_cl;
    logic        conflict;
  } out_t;

  typedef struct packed {
    logic [15:0] device;
    logic [31:0] file;
    logic [15:0] file_cl;
    logic [15:0] disk_cl;
  } entry_t;

  // Per-cell command for the current cycle.
  typedef struct packed {
    logic shift;     // take the neighbor's entry (move-to-front)
    logic clr_file;  // empty the entry if it belongs to the request's file
    logic clr_dev;   // empty the entry if it belongs to the request's device
  } cell_ctrl_t;

  // Per-cell compare results against the current request.
  typedef struct packed {
    logic same_file;
    logic key_le;
    logic key_eq;
    logic disk_ne;
  } cell_flags_t;

endpackage

// File: design/cmap_cell.sv
// One list position of the cache: entry storage, compares and neighbor shift.
`timescale 1ns / 1ps
module cmap_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmap_pkg::entry_t     req_i,
  input  cmap_pkg::cell_ctrl_t ctrl_i,
  input  cmap_pkg::entry_t     prev_i,
  output cmap_pkg::entry_t     entry_o,
  output cmap_pkg::cell_flags_t flags_o
);

  logic [15:0] device_q, device_d;
  logic [31:0] file_q;
  logic [15:0] fc_q;
  logic [15:0] dc_q;
  logic        dev_match;

  assign dev_match = (device_q != 16'd0) && (device_q == req_i.device);

  assign flags_o.same_file = dev_match && (file_q == req_i.file);
  assign flags_o.key_le    = fc_q <= req_i.file_cl;
  assign flags_o.key_eq    = fc_q == req_i.file_cl;
  assign flags_o.disk_ne   = dc_q != req_i.disk_cl;

  always_comb begin
    device_d = device_q;
    if (ctrl_i.shift) begin
      device_d = prev_i.device;
    end else if ((ctrl_i.clr_file && flags_o.same_file) || (ctrl_i.clr_dev && dev_match)) begin
      device_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_q <= 16'd0;
    end else begin
      device_q <= device_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      file_q <= prev_i.file;
      fc_q   <= prev_i.file_cl;
      dc_q   <= prev_i.disk_cl;
    end
  end

  assign entry_o = '{device: device_q, file: file_q, file_cl: fc_q, disk_cl: dc_q};

endmodule

// File: design/cluster_map_lru_cache_top.sv
// Cluster map cache: move-to-front list of cells, scan sequencer and result register.
`timescale 1ns / 1ps
// Fully associative cache of (device, file, file cluster) -> disk cluster, kept as a
// move-to-front list in a chain of ENTRIES cells; cell 0 is the front. One transaction
// is worked at a time, and a new one is taken while the previous result still waits in
// the output register. A lookup scans every cell, one per cycle. An add scans until the
// first match among the first ENTRIES-1 cells, then in the apply state shifts the chain
// or clears the file. Both invalidates skip the scan and go straight to the apply state.
// The input takes the next transaction in the cycle after the result is loaded; while
// the output register is full and stalled, the finished result waits and the input
// stays stalled. A single scan pointer steps over the cells.
module cluster_map_lru_cache_top #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cmap_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cmap_pkg::out_t  out_data_o
);

  `include "assert_macros.svh"

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);
  localparam logic [IdxW-1:0] AddLastIdx = IdxW'(ENTRIES - 2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_DONE
  } state_e;

  state_e          state_q;
  cmap_pkg::in_t   req_q;
  logic [IdxW-1:0] k_q;
  logic [IdxW-1:0] pos_q;
  logic            found_q;
  logic            conflict_q;
  logic            hit_q;
  logic [15:0]     best_fc_q;
  logic [15:0]     best_dc_q;
  logic            out_valid_q;
  cmap_pkg::out_t  out_q;

  cmap_pkg::entry_t      req_entry;
  cmap_pkg::entry_t      entries   [ENTRIES];
  cmap_pkg::cell_flags_t flags     [ENTRIES];
  cmap_pkg::cell_ctrl_t  ctrl      [ENTRIES];
  cmap_pkg::entry_t      sel_entry;
  cmap_pkg::cell_flags_t sel_flags;

  logic            take;
  logic            add_match;
  logic            clr_file_cmd;
  logic            clr_dev_cmd;
  logic            mv_cmd;
  logic [IdxW-1:0] move_pos;
  logic            is_lookup;
  logic            is_add;
  logic            out_load;
  logic            in_acc;
  cmap_pkg::out_t  result;

  assign req_entry = '{device: req_q.device_id, file: req_q.file_id,
                       file_cl: req_q.cluster_key, disk_cl: req_q.disk_cl};

  assign is_lookup = req_q.mode == cmap_pkg::MODE_LOOKUP;
  assign is_add    = req_q.mode == cmap_pkg::MODE_ADD;

  // Cell 0 loads the request; a refreshed entry equals the request, so the same
  // shift serves both refresh and tail replacement.
  assign clr_file_cmd = (state_q == S_APPLY) &&
                        ((req_q.mode == cmap_pkg::MODE_INV_FILE) ||
                         (is_add && found_q && conflict_q));
  assign clr_dev_cmd  = (state_q == S_APPLY) && (req_q.mode == cmap_pkg::MODE_INV_DEV);
  assign mv_cmd       = (state_q == S_APPLY) && is_add && !(found_q && conflict_q);
  assign move_pos     = found_q ? pos_q : LastIdx;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign ctrl[g] = '{shift: mv_cmd && (IdxW'(g) <= move_pos),
                       clr_file: clr_file_cmd, clr_dev: clr_dev_cmd};
    if (g == 0) begin : g_head
      cmap_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .req_i   (req_entry),
        .ctrl_i  (ctrl[g]),
        .prev_i  (req_entry),
        .entry_o (entries[g]),
        .flags_o (flags[g])
      );
    end else begin : g_body
      cmap_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .req_i   (req_entry),
        .ctrl_i  (ctrl[g]),
        .prev_i  (entries[g-1]),
        .entry_o (entries[g]),
        .flags_o (flags[g])
      );
    end
  end

  assign sel_entry = entries[k_q];
  assign sel_flags = flags[k_q];

  assign take      = sel_flags.same_file && sel_flags.key_le &&
                     (sel_entry.file_cl > best_fc_q);
  assign add_match = sel_flags.same_file && sel_flags.key_eq;

  assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign in_acc    = in_valid_i && !in_stall_o;

  always_comb begin
    result = '0;
    if (is_lookup) begin
      result.hit         = hit_q;
      result.exact       = hit_q && (best_fc_q == req_q.cluster_key);
      result.out_file_cl = best_fc_q;
      result.out_disk_cl = best_dc_q;
    end else if (is_add) begin
      result.conflict = found_q && conflict_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      k_q         <= '0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      conflict_q  <= 1'b0;
      hit_q       <= 1'b0;
      best_fc_q   <= '0;
      best_dc_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= result;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q      <= in_data_i;
            k_q        <= '0;
            found_q    <= 1'b0;
            conflict_q <= 1'b0;
            hit_q      <= 1'b0;
            best_fc_q  <= in_data_i.prior_cluster;
            best_dc_q  <= in_data_i.disk_cl;
            if ((in_data_i.mode == cmap_pkg::MODE_LOOKUP) ||
                (in_data_i.mode == cmap_pkg::MODE_ADD)) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_APPLY;
            end
          end
        end
        S_SCAN: begin
          k_q <= k_q + 1'b1;
          if (is_lookup) begin
            if (take) begin
              hit_q     <= 1'b1;
              best_fc_q <= sel_entry.file_cl;
              best_dc_q <= sel_entry.disk_cl;
            end
            if (k_q == LastIdx) begin
              state_q <= S_DONE;
            end
          end else begin
            // tail position is never compared
            if (add_match) begin
              found_q    <= 1'b1;
              pos_q      <= k_q;
              conflict_q <= sel_flags.disk_ne;
              state_q    <= S_APPLY;
            end else if (k_q == AddLastIdx) begin
              state_q <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_AT(a_accept_busy, clk_i, rst_ni, in_acc |=> state_q == S_SCAN || state_q == S_APPLY)
  `ASSERT_NEVER(a_one_cell_cmd, clk_i, rst_ni, !$onehot0({mv_cmd, clr_file_cmd, clr_dev_cmd}))
  `ASSERT_NEVER(a_exact_needs_hit, clk_i, rst_ni, out_valid_o && out_data_o.exact && !out_data_o.hit)
  `ASSERT_NEVER(a_hit_xor_conflict, clk_i, rst_ni, out_valid_o && out_data_o.hit && out_data_o.conflict)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the cluster map LRU cache: mirror model, stimulus, result checks.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned N_ENTRIES     = 8;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = N_ENTRIES + 6;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned POOL_SIZE     = 3;

  localparam logic [15:0] DEV_A  = 16'hA5A5;
  localparam logic [31:0] FILE_F = 32'h0000_1234;
  localparam logic [31:0] FILE_G = 32'hFFFF_0001;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  cmap_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  cmap_pkg::out_t out_data_o;

  // mirror of the cache contents and list order
  logic [15:0] mir_dev  [N_ENTRIES];
  logic [31:0] mir_file [N_ENTRIES];
  logic [15:0] mir_fcl  [N_ENTRIES];
  logic [15:0] mir_dcl  [N_ENTRIES];
  int unsigned mir_pos  [N_ENTRIES];

  cmap_pkg::out_t pending_results[$];
  bit          gaps_on = 1'b1;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  logic [15:0] dev_pool  [POOL_SIZE];
  logic [31:0] file_pool [POOL_SIZE];

  cluster_map_lru_cache_top #(
    .ENTRIES(N_ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit owns(int unsigned e, logic [15:0] dev, logic [31:0] file);
    return mir_dev[e] != '0 && mir_dev[e] == dev && mir_file[e] == file;
  endfunction

  function automatic void drop_file(logic [15:0] dev, logic [31:0] file);
    for (int unsigned i = 0; i < N_ENTRIES; i++)
      if (owns(i, dev, file)) mir_dev[i] = '0;
  endfunction

  function automatic void bump_front(int unsigned e);
    int unsigned was;
    was = mir_pos[e];
    for (int unsigned i = 0; i < N_ENTRIES; i++)
      if (mir_pos[i] < was) mir_pos[i]++;
    mir_pos[e] = 0;
  endfunction

  // Applies one request to the mirror and returns the result it should produce.
  function automatic cmap_pkg::out_t cache_apply(cmap_pkg::in_t req);
    int unsigned    slot_at [N_ENTRIES];
    int unsigned    e;
    bit             found;
    logic [15:0]    best_fc;
    logic [15:0]    best_dc;
    cmap_pkg::out_t res;
    res = '0;
    found = 1'b0;
    for (int unsigned i = 0; i < N_ENTRIES; i++) slot_at[mir_pos[i]] = i;
    case (req.mode)
      cmap_pkg::MODE_LOOKUP: begin
        best_fc = req.prior_cluster;
        best_dc = req.disk_cl;
        for (int unsigned k = 0; k < N_ENTRIES && !found; k++) begin
          e = slot_at[k];
          if (owns(e, req.device_id, req.file_id) && mir_fcl[e] <= req.cluster_key &&
              mir_fcl[e] > best_fc) begin
            best_fc = mir_fcl[e];
            best_dc = mir_dcl[e];
            res.hit = 1'b1;
            if (best_fc == req.cluster_key) begin
              res.exact = 1'b1;
              found = 1'b1;
            end
          end
        end
        res.out_file_cl = best_fc;
        res.out_disk_cl = best_dc;
      end
      cmap_pkg::MODE_ADD: begin
        // tail is never compared
        for (int unsigned k = 0; k + 1 < N_ENTRIES && !found; k++) begin
          e = slot_at[k];
          if (owns(e, req.device_id, req.file_id) && mir_fcl[e] == req.cluster_key) begin
            found = 1'b1;
            if (mir_dcl[e] != req.disk_cl) begin
              res.conflict = 1'b1;
              drop_file(req.device_id, req.file_id);
            end else begin
              bump_front(e);
            end
          end
        end
        if (!found) begin
          e = slot_at[N_ENTRIES-1];
          mir_dev[e]  = req.device_id;
          mir_file[e] = req.file_id;
          mir_fcl[e]  = req.cluster_key;
          mir_dcl[e]  = req.disk_cl;
          bump_front(e);
        end
      end
      cmap_pkg::MODE_INV_FILE: drop_file(req.device_id, req.file_id);
      default: begin
        for (int unsigned i = 0; i < N_ENTRIES; i++)
          if (mir_dev[i] != '0 && mir_dev[i] == req.device_id) mir_dev[i] = '0;
      end
    endcase
    return res;
  endfunction

  function automatic cmap_pkg::in_t req_of(cmap_pkg::mode_e m, logic [15:0] dev,
                                           logic [31:0] file, logic [15:0] key,
                                           logic [15:0] prior, logic [15:0] disk);
    cmap_pkg::in_t r;
    r.mode          = m;
    r.device_id     = dev;
    r.file_id       = file;
    r.cluster_key   = key;
    r.prior_cluster = prior;
    r.disk_cl       = disk;
    return r;
  endfunction

  // Mostly requests over a small set of files and keys, so adds and lookups meet.
  function automatic cmap_pkg::in_t random_req();
    cmap_pkg::in_t r;
    int unsigned   roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      r.mode = cmap_pkg::MODE_LOOKUP;
    else if (roll < 82) r.mode = cmap_pkg::MODE_ADD;
    else if (roll < 94) r.mode = cmap_pkg::MODE_INV_FILE;
    else                r.mode = cmap_pkg::MODE_INV_DEV;
    r.device_id     = dev_pool[$urandom_range(0, POOL_SIZE - 1)];
    r.file_id       = file_pool[$urandom_range(0, POOL_SIZE - 1)];
    r.cluster_key   = 16'($urandom_range(0, 15));
    r.prior_cluster = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15)) : 16'd0;
    // stable disk mapping per key: most adds refresh, a few conflict
    r.disk_cl       = r.cluster_key ^ r.file_id[15:0] ^ r.device_id;
    if ($urandom_range(0, 9) == 0) r.disk_cl = 16'($urandom);
    if ($urandom_range(0, 99) < 12) begin
      r.device_id     = 16'($urandom);
      r.file_id       = $urandom;
      r.cluster_key   = 16'($urandom);
      r.prior_cluster = 16'($urandom);
      r.disk_cl       = 16'($urandom);
    end
    return r;
  endfunction

  task automatic send_req(cmap_pkg::in_t req);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(cache_apply(req));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_empty_cache();
    send_req(req_of(cmap_pkg::MODE_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000,
                    16'hFFFF));
    send_req(req_of(cmap_pkg::MODE_INV_DEV, 16'h0000, 32'h0, 16'h0, 16'h0, 16'h0));
    wait_drained();
  endtask

  task automatic test_add_lookup();
    send_req(req_of(cmap_pkg::MODE_ADD, DEV_A, FILE_F, 16'd10, 16'd0, 16'd100));
    send_req(req_of(cmap_pkg::MODE_ADD, DEV_A, FILE_F, 16'd20, 16'd0, 16'd200));
    send_req(req_of(cmap_pkg::MODE_ADD, DEV_A, FILE_F, 16'd30, 16'd0, 16'd300));
    send_req(req_of(cmap_pkg::MODE_LOOKUP, DEV_A, FILE_F, 16'd25, 16'd0, 16'h0ABC));
    send_req(req_of(cmap_pkg::MODE_LOOKUP, DEV_A, FILE_F, 16'd30, 16'd0, 16'h0ABC));
    send_req(req_of(cmap_pkg::MODE_LOOKUP, DEV_A, FILE_F, 16'd25, 16'd20, 16'h0DEF));
    // prior at or past the target: nothing can qualify
    send_req(req_of(cmap_pkg::MODE_LOOKUP, DEV_A, FILE_F, 16'd30, 16'd40, 16'h1357));
    wait_drained();
  endtask

  task automatic test_refresh_conflict();
    send_req(req_of(cmap_pkg::MODE_ADD, DEV_A, FILE_F, 16'd20, 16'd0, 16'd200));
    send_req(req_of(cmap_pkg::MODE_ADD, DEV_A, FILE_F, 16'd20, 16'd0, 16'd999));
    send_req(req_of(cmap_pkg::MODE_LOOKUP, DEV_A, FILE_F, 16'd30, 16'd0, 16'h2468));
    wait_drained();
  endtask

  task automatic test_tail_replace();
    for (int unsigned k = 1; k <= N_ENTRIES; k++)
      send_req(req_of(cmap_pkg::MODE_ADD, DEV_A, FILE_G, 16'(k), 16'd0, 16'(16'h100 + k)));
    // key 1 now sits at the tail, so a different disk cluster replaces it quietly
    send_req(req_of(cmap_pkg::MODE_ADD, DEV_A, FILE_G, 16'd1, 16'd0, 16'hBEEF));
    send_req(req_of(cmap_pkg::MODE_LOOKUP, DEV_A, FILE_G, 16'd1, 16'd0, 16'd0));
    send_req(req_of(cmap_pkg::MODE_ADD, 16'h0000, FILE_G, 16'd2, 16'd0, 16'd0));
    send_req(req_of(cmap_pkg::MODE_LOOKUP, DEV_A, FILE_G, 16'd2, 16'd0, 16'd0));
    send_req(req_of(cmap_pkg::MODE_INV_FILE, DEV_A, FILE_G, 16'd0, 16'd0, 16'd0));
    send_req(req_of(cmap_pkg::MODE_INV_DEV, DEV_A, 32'h0, 16'd0, 16'd0, 16'd0));
    wait_drained();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (200) send_req(random_req());
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_output_hold();
    gaps_on = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (60) send_req(random_req());
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    repeat (720) send_req(random_req());
    wait_drained();
  endtask

  // receiver side: random stalls, or a long hold when one is requested
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= gaps_on && ($urandom_range(0, 99) < 13);
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    cmap_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected transaction, expected none, actual %p",
                 $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 16'(want.hit), 16'(out_data_o.hit));
        check_field("exact", 16'(want.exact), 16'(out_data_o.exact));
        check_field("out_file_cl", want.out_file_cl, out_data_o.out_file_cl);
        check_field("out_disk_cl", want.out_disk_cl, out_data_o.out_disk_cl);
        check_field("conflict", 16'(want.conflict), 16'(out_data_o.conflict));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int unsigned i = 0; i < N_ENTRIES; i++) begin
      mir_dev[i]  = '0;
      mir_file[i] = '0;
      mir_fcl[i]  = '0;
      mir_dcl[i]  = '0;
      mir_pos[i]  = i;
    end
    for (int unsigned i = 0; i < POOL_SIZE; i++) begin
      dev_pool[i]  = 16'($urandom_range(1, 65535));
      file_pool[i] = $urandom;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_cache();
    test_add_lookup();
    test_refresh_conflict();
    test_tail_replace();
    test_back_to_back();
    test_output_hold();
    test_random_traffic();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
